### src/ast_pkg.sv
// shared types, character codes and helpers for the assembly source tokenizer
`timescale 1ns / 1ps

package ast_pkg;

    localparam int NEST_BITS_DEF = 8;
    localparam int SLOTS         = 4;
    localparam int SLOT_IDX_W    = $clog2(SLOTS);
    localparam int CNT_W         = $clog2(SLOTS + 1);
    localparam int FIFO_DEPTH    = 4;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_BLOCK   = 2'd1,
        MODE_COMMENT = 2'd2
    } ast_mode_t;

    typedef struct packed {
        logic [7:0] character;
        logic       final_req;
    } ast_in_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] token_char;
        logic       last;
    } ast_out_t;

    typedef struct packed {
        ast_out_t [SLOTS-1:0] slot;
        logic [CNT_W-1:0]     count;
    } ast_group_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ast_fifo_ctl_t;

    function automatic logic ast_is_blank(logic [7:0] c);
        return c == CH_NL || c == CH_CR || c == CH_TAB || c == CH_VT ||
               c == CH_SPACE || c == CH_FF;
    endfunction

    function automatic logic ast_is_single(logic [7:0] c);
        return c == CH_LBRACK || c == CH_RBRACK || c == CH_COMMA || c == CH_COLON;
    endfunction

    function automatic ast_group_t ast_put(ast_group_t g, logic kind, logic [7:0] ch);
        ast_group_t r;
        r = g;
        if (r.count < CNT_W'(SLOTS)) begin
            r.slot[r.count[SLOT_IDX_W-1:0]].kind       = kind;
            r.slot[r.count[SLOT_IDX_W-1:0]].token_char = ch;
            r.slot[r.count[SLOT_IDX_W-1:0]].last       = 1'b0;
            r.count = r.count + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

### src/ast_lexer.sv
// tokenizer state registers and single-pass next-state and result group logic
`timescale 1ns / 1ps

module ast_lexer #(
    parameter int NEST_BITS = ast_pkg::NEST_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  ast_pkg::ast_in_t    item,
    output ast_pkg::ast_group_t group
);

    ast_pkg::ast_mode_t   mode_reg, mode_next;
    logic                 quote_reg, quote_next;
    logic [NEST_BITS-1:0] nest_reg, nest_next;
    logic                 open_reg, open_next;
    logic                 skip_reg, skip_next;
    logic                 slash_reg, slash_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ast_pkg::MODE_PLAIN;
            quote_reg <= 1'b0;
            nest_reg  <= '0;
            open_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            slash_reg <= 1'b0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            nest_reg  <= nest_next;
            open_reg  <= open_next;
            skip_reg  <= skip_next;
            slash_reg <= slash_next;
        end
    end

    always_comb begin
        ast_pkg::ast_group_t g;
        logic [7:0]          c;
        logic                consumed;
        g          = '0;
        c          = item.character;
        consumed   = 1'b0;
        mode_next  = mode_reg;
        quote_next = quote_reg;
        nest_next  = nest_reg;
        open_next  = open_reg;
        skip_next  = skip_reg;
        slash_next = slash_reg;

        if (skip_reg) begin
            skip_next = 1'b0;
        end else if (mode_reg == ast_pkg::MODE_BLOCK) begin
            if (quote_reg) begin
                if (c == ast_pkg::CH_QUOTE) begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                    open_next = 1'b0;
                    mode_next = ast_pkg::MODE_PLAIN;
                end else if (c == ast_pkg::CH_BSLASH) begin
                    skip_next = 1'b1;
                end else begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    open_next = 1'b1;
                end
            end else begin
                g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                open_next = 1'b1;
                if (c == ast_pkg::CH_LPAREN) begin
                    if (nest_reg != '1) begin
                        nest_next = nest_reg + NEST_BITS'(1);
                    end
                end else if (c == ast_pkg::CH_RPAREN) begin
                    if (nest_reg != '0) begin
                        nest_next = nest_reg - NEST_BITS'(1);
                    end
                    if (nest_next == '0) begin
                        g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                        open_next = 1'b0;
                        mode_next = ast_pkg::MODE_PLAIN;
                    end
                end
            end
        end else if (mode_reg == ast_pkg::MODE_COMMENT) begin
            if (c == ast_pkg::CH_NL) begin
                mode_next = ast_pkg::MODE_PLAIN;
                if (open_reg) begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                end
                open_next = 1'b0;
            end
        end else begin
            mode_next = ast_pkg::MODE_PLAIN;
            if (slash_reg) begin
                slash_next = 1'b0;
                if (c == ast_pkg::CH_SLASH) begin
                    mode_next = ast_pkg::MODE_COMMENT;
                    consumed  = 1'b1;
                end else begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, ast_pkg::CH_SLASH);
                    open_next = 1'b1;
                end
            end
            if (!consumed) begin
                if (ast_pkg::ast_is_blank(c)) begin
                    if (open_next) begin
                        g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                    end
                    open_next = 1'b0;
                end else if (c == ast_pkg::CH_BSLASH) begin
                    skip_next = 1'b1;
                end else if (c == ast_pkg::CH_QUOTE) begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    open_next  = 1'b1;
                    mode_next  = ast_pkg::MODE_BLOCK;
                    quote_next = 1'b1;
                end else if (c == ast_pkg::CH_LPAREN) begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    open_next  = 1'b1;
                    mode_next  = ast_pkg::MODE_BLOCK;
                    quote_next = 1'b0;
                    nest_next  = NEST_BITS'(1);
                end else if (ast_pkg::ast_is_single(c)) begin
                    if (open_next) begin
                        g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                    end
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
                    open_next = 1'b0;
                end else if (c == ast_pkg::CH_SLASH) begin
                    slash_next = 1'b1;
                end else begin
                    g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, c);
                    open_next = 1'b1;
                end
            end
        end

        // end of text: flush held slash and open token, back to reset state
        if (item.final_req) begin
            if (slash_next) begin
                g = ast_pkg::ast_put(g, ast_pkg::KIND_CHAR, ast_pkg::CH_SLASH);
                open_next = 1'b1;
            end
            if (open_next) begin
                g = ast_pkg::ast_put(g, ast_pkg::KIND_END, 8'h00);
            end
            mode_next  = ast_pkg::MODE_PLAIN;
            quote_next = 1'b0;
            nest_next  = '0;
            open_next  = 1'b0;
            skip_next  = 1'b0;
            slash_next = 1'b0;
        end

        if (g.count != '0) begin
            g.slot[ast_pkg::SLOT_IDX_W'(g.count - ast_pkg::CNT_W'(1))].last = 1'b1;
        end
        group = g;
    end

endmodule

### src/ast_group_fifo.sv
// small register queue of result groups between the lexer and the output drain
`timescale 1ns / 1ps

module ast_group_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ast_pkg::ast_fifo_ctl_t ctl_in,
    input  ast_pkg::ast_group_t   wr_data,
    output logic                  full,
    output logic                  empty,
    output ast_pkg::ast_group_t   rd_data
);

    localparam int DEPTH = ast_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ast_pkg::ast_group_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (ctl_in.push) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
        if (ctl_in.pop) begin
            rd_ptr_next = ptr_inc(rd_ptr_reg);
        end
        if (ctl_in.push && !ctl_in.pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!ctl_in.push && ctl_in.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/assembly_source_tokenizer.sv
// top level: input register, lexer, result group queue and output word drain
// path: a word is taken into the input register, its results are written into the queue
// and the first result word is offered from the queue head
// throughput, with m_ready high: one input word per cycle if each yields at most one
// result; output drains one result per cycle, up to four per word, via a 4-deep queue
// reset: synchronous active-low aresetn clears lexer state, queue and handshakes
`timescale 1ns / 1ps

module assembly_source_tokenizer #(
    parameter int NEST_BITS = ast_pkg::NEST_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ast_pkg::ast_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ast_pkg::ast_out_t m_data
);

    logic                       in_valid_reg, in_valid_next;
    ast_pkg::ast_in_t           in_item_reg;
    logic                       advance;
    ast_pkg::ast_group_t        group;
    ast_pkg::ast_group_t        head;
    ast_pkg::ast_fifo_ctl_t     fifo_ctl;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic [ast_pkg::SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic                       head_done;

    assign advance = in_valid_reg && !fifo_full;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    ast_lexer #(
        .NEST_BITS(NEST_BITS)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .group   (group)
    );

    assign head_done = ({1'b0, idx_reg} == (head.count - ast_pkg::CNT_W'(1)));

    always_comb begin
        fifo_ctl.push = advance && (group.count != '0);
        fifo_ctl.pop  = m_valid && m_ready && head_done;
    end

    ast_group_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (fifo_ctl),
        .wr_data (group),
        .full    (fifo_full),
        .empty   (fifo_empty),
        .rd_data (head)
    );

    assign m_valid = !fifo_empty;
    assign m_data  = head.slot[idx_reg];

    always_comb begin
        idx_next = idx_reg;
        if (m_valid && m_ready) begin
            if (head_done) begin
                idx_next = '0;
            end else begin
                idx_next = idx_reg + ast_pkg::SLOT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else begin
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTH
    // queued groups always carry at least one word
    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (head.count != '0))
        else $error("empty result group in queue");

    // word index stays inside the head group
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, idx_reg} < head.count))
        else $error("result index past end of group");

    // last flag marks exactly the final word of a group
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == head_done))
        else $error("last flag out of place");

    // a full queue holds the pending input word
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && fifo_full) |=> in_valid_reg)
        else $error("input word lost while queue full");
`endif

endmodule
